// File: design/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types for the unit sphere collision response block.
// ----------------------------------------------------------------------------
package usc_pkg;

	typedef enum logic [1:0] {
		CODE_APART      = 2'd0,
		CODE_RESOLVED   = 2'd1,
		CODE_COINCIDENT = 2'd2
	} code_t;

	typedef struct packed {
		logic signed [31:0] pos_a_x;
		logic signed [31:0] pos_a_y;
		logic signed [31:0] pos_a_z;
		logic signed [31:0] pos_b_x;
		logic signed [31:0] pos_b_y;
		logic signed [31:0] pos_b_z;
		logic signed [31:0] vel_a_x;
		logic signed [31:0] vel_a_y;
		logic signed [31:0] vel_a_z;
		logic signed [31:0] vel_b_x;
		logic signed [31:0] vel_b_y;
		logic signed [31:0] vel_b_z;
	} in_t;

	typedef struct packed {
		code_t              contact_code;
		logic signed [31:0] new_pos_a_x;
		logic signed [31:0] new_pos_a_y;
		logic signed [31:0] new_pos_a_z;
		logic signed [31:0] new_vel_a_x;
		logic signed [31:0] new_vel_a_y;
		logic signed [31:0] new_vel_a_z;
		logic signed [31:0] new_vel_b_x;
		logic signed [31:0] new_vel_b_y;
		logic signed [31:0] new_vel_b_z;
	} out_t;

endpackage

// File: design/usc_stream.sv
// ----------------------------------------------------------------------------
// usc_stream
// Valid/ready channel carrying one request of payload type T.
// ----------------------------------------------------------------------------
interface usc_stream #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/unit_sphere_collision_response.sv
// Throughput: one request per cycle while the output is not stalled; the sqrt and the three
// normal dividers are unrolled two steps per stage, which sets the pipeline depth.
// Backpressure stalls every stage together; nothing is dropped or repeated.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// unit_sphere_collision_response
// Equal-mass unit sphere contact: push-out and impulse exchange, Q16.16.
// ----------------------------------------------------------------------------
module unit_sphere_collision_response (
	input  logic            clk,
	input  logic            arst_n,
	usc_stream.sink         pairs,
	usc_stream.source       results
);
	import usc_pkg::*;

	localparam int NST  = 27;
	localparam int K_SQ = 3;   // first sqrt stage
	localparam int K_DI = 12;  // divider set-up
	localparam int K_DV = 13;  // first divide stage
	localparam int K_N  = 22;
	localparam int K_M1 = 23;
	localparam int K_M2 = 24;
	localparam int K_M3 = 25;
	localparam int K_F  = 26;
	localparam int DIV_STEPS = 17;

	typedef struct packed {
		code_t             code;
		logic              far;
		logic [2:0][31:0]  pa;
		logic [2:0][31:0]  va;
		logic [2:0][31:0]  vb;
		logic [2:0][32:0]  d;
		logic [2:0][35:0]  sq;
		logic [35:0]       rad;
		logic [19:0]       rrem;
		logic [17:0]       root;
		logic [2:0][16:0]  nb;
		logic [2:0]        neg;
		logic [2:0][17:0]  drem;
		logic [2:0][16:0]  q;
		logic [2:0][17:0]  n;
		logic [17:0]       ovl;
		logic [2:0][32:0]  dv;
		logic [2:0][35:0]  psh;
		logic [2:0][50:0]  pdot;
		logic [2:0][31:0]  npa;
		logic [36:0]       j;
		logic [2:0][54:0]  pimp;
		logic [2:0][31:0]  nva;
		logic [2:0][31:0]  nvb;
	} w_t;

	function automatic logic [31:0] sat32(input logic signed [55:0] v);
		if (v > 56'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -56'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	// divide by 65536, rounding toward zero
	function automatic logic signed [55:0] tr16(input logic signed [55:0] x);
		return (x + (x[55] ? 56'sd65535 : 56'sd0)) >>> 16;
	endfunction

	w_t              pipe_s [NST];
	w_t              nxt    [NST];
	logic [NST-1:0]  vld_s;
	logic            en;

	assign en = !vld_s[NST-1] || results.ready;
	assign pairs.ready = en;

	for (genvar k = 0; k < NST; k++) begin : g_st
		if (k == 0) begin : g_in
			logic [2:0][31:0] pb;
			always_comb begin
				nxt[k] = '0;
				nxt[k].pa = {pairs.data.pos_a_z, pairs.data.pos_a_y, pairs.data.pos_a_x};
				pb        = {pairs.data.pos_b_z, pairs.data.pos_b_y, pairs.data.pos_b_x};
				nxt[k].va = {pairs.data.vel_a_z, pairs.data.vel_a_y, pairs.data.vel_a_x};
				nxt[k].vb = {pairs.data.vel_b_z, pairs.data.vel_b_y, pairs.data.vel_b_x};
				nxt[k].far = 1'b0;
				for (int c = 0; c < 3; c++) begin
					nxt[k].d[c] = 33'($signed(pb[c])) - 33'($signed(nxt[k].pa[c]));
					if ($signed(nxt[k].d[c]) > 33'sd131072 ||
							$signed(nxt[k].d[c]) < -33'sd131072)
						nxt[k].far = 1'b1;
				end
			end
		end else if (k == 1) begin : g_sq
			always_comb begin
				nxt[k] = pipe_s[k-1];
				for (int c = 0; c < 3; c++)
					nxt[k].sq[c] = 36'($signed(pipe_s[k-1].d[c][17:0]) *
						$signed(pipe_s[k-1].d[c][17:0]));
			end
		end else if (k == 2) begin : g_sum
			logic [37:0] s;
			always_comb begin
				nxt[k] = pipe_s[k-1];
				s = 38'(pipe_s[k-1].sq[0]) + 38'(pipe_s[k-1].sq[1]) +
					38'(pipe_s[k-1].sq[2]);
				if (pipe_s[k-1].far || s > 38'h4_0000_0000)
					nxt[k].code = CODE_APART;
				else if (s == '0)
					nxt[k].code = CODE_COINCIDENT;
				else
					nxt[k].code = CODE_RESOLVED;
				nxt[k].rad  = s[35:0];
				nxt[k].rrem = '0;
				nxt[k].root = '0;
			end
		end else if (k < K_DI) begin : g_rt
			// two root bits per stage, each from one radix-4 digit of the radicand
			logic [21:0] t;
			logic [21:0] trial;
			always_comb begin
				nxt[k] = pipe_s[k-1];
				t = '0;
				trial = '0;
				for (int i = 0; i < 2; i++) begin
					t     = {nxt[k].rrem, nxt[k].rad[35:34]};
					trial = {2'b00, nxt[k].root, 2'b01};
					nxt[k].rad = {nxt[k].rad[33:0], 2'b00};
					if (t >= trial) begin
						nxt[k].rrem = 20'(t - trial);
						nxt[k].root = {nxt[k].root[16:0], 1'b1};
					end else begin
						nxt[k].rrem = t[19:0];
						nxt[k].root = {nxt[k].root[16:0], 1'b0};
					end
				end
			end
		end else if (k == K_DI) begin : g_di
			logic [2:0][17:0] mag;
			always_comb begin
				nxt[k] = pipe_s[k-1];
				for (int c = 0; c < 3; c++) begin
					nxt[k].neg[c] = pipe_s[k-1].d[c][32];
					mag[c] = pipe_s[k-1].d[c][32] ? 18'(-pipe_s[k-1].d[c]) :
						pipe_s[k-1].d[c][17:0];
					nxt[k].drem[c] = {1'b0, mag[c][17:1]};
					nxt[k].nb[c]   = {mag[c][0], 16'h0000};
					nxt[k].q[c]    = '0;
				end
			end
		end else if (k < K_N) begin : g_dv
			// restoring division of |d|*65536 by dist, two quotient bits per stage
			logic [18:0] r;
			always_comb begin
				nxt[k] = pipe_s[k-1];
				r = '0;
				for (int c = 0; c < 3; c++) begin
					for (int i = 0; i < 2; i++) begin
						if (2 * (k - K_DV) + i < DIV_STEPS) begin
							r = {nxt[k].drem[c], nxt[k].nb[c][16]};
							nxt[k].nb[c] = {nxt[k].nb[c][15:0], 1'b0};
							if (r >= {1'b0, nxt[k].root}) begin
								nxt[k].drem[c] = 18'(r - {1'b0, nxt[k].root});
								nxt[k].q[c]    = {nxt[k].q[c][15:0], 1'b1};
							end else begin
								nxt[k].drem[c] = r[17:0];
								nxt[k].q[c]    = {nxt[k].q[c][15:0], 1'b0};
							end
						end
					end
				end
			end
		end else if (k == K_N) begin : g_n
			always_comb begin
				nxt[k] = pipe_s[k-1];
				nxt[k].ovl = 18'(19'd131072 - {1'b0, pipe_s[k-1].root});
				for (int c = 0; c < 3; c++) begin
					nxt[k].n[c] = pipe_s[k-1].neg[c] ? 18'(-{1'b0, pipe_s[k-1].q[c]}) :
						{1'b0, pipe_s[k-1].q[c]};
					nxt[k].dv[c] = 33'($signed(pipe_s[k-1].va[c])) -
						33'($signed(pipe_s[k-1].vb[c]));
				end
			end
		end else if (k == K_M1) begin : g_m1
			always_comb begin
				nxt[k] = pipe_s[k-1];
				for (int c = 0; c < 3; c++) begin
					nxt[k].psh[c] = 36'($signed({1'b0, pipe_s[k-1].ovl}) *
						$signed(pipe_s[k-1].n[c]));
					nxt[k].pdot[c] = 51'($signed(pipe_s[k-1].dv[c]) *
						$signed(pipe_s[k-1].n[c]));
				end
			end
		end else if (k == K_M2) begin : g_m2
			logic signed [55:0] dsum;
			always_comb begin
				nxt[k] = pipe_s[k-1];
				dsum = 56'($signed(pipe_s[k-1].pdot[0])) +
					56'($signed(pipe_s[k-1].pdot[1])) +
					56'($signed(pipe_s[k-1].pdot[2]));
				nxt[k].j = 37'(tr16(dsum));
				for (int c = 0; c < 3; c++)
					nxt[k].npa[c] = sat32(56'($signed(pipe_s[k-1].pa[c])) -
						tr16(56'($signed(pipe_s[k-1].psh[c]))));
			end
		end else if (k == K_M3) begin : g_m3
			always_comb begin
				nxt[k] = pipe_s[k-1];
				for (int c = 0; c < 3; c++)
					nxt[k].pimp[c] = 55'($signed(pipe_s[k-1].j) *
						$signed(pipe_s[k-1].n[c]));
			end
		end else begin : g_fin
			logic signed [55:0] imp;
			always_comb begin
				nxt[k] = pipe_s[k-1];
				imp = '0;
				for (int c = 0; c < 3; c++) begin
					imp = tr16(56'($signed(pipe_s[k-1].pimp[c])));
					if (pipe_s[k-1].code == CODE_RESOLVED) begin
						nxt[k].nva[c] = sat32(56'($signed(pipe_s[k-1].va[c])) - imp);
						nxt[k].nvb[c] = sat32(56'($signed(pipe_s[k-1].vb[c])) + imp);
					end else begin
						nxt[k].npa[c] = pipe_s[k-1].pa[c];
						nxt[k].nva[c] = pipe_s[k-1].va[c];
						nxt[k].nvb[c] = pipe_s[k-1].vb[c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], pairs.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++)
				pipe_s[k] <= nxt[k];
		end
	end

	assign results.valid = vld_s[NST-1];
	always_comb begin
		results.data.contact_code = pipe_s[NST-1].code;
		results.data.new_pos_a_x  = pipe_s[NST-1].npa[0];
		results.data.new_pos_a_y  = pipe_s[NST-1].npa[1];
		results.data.new_pos_a_z  = pipe_s[NST-1].npa[2];
		results.data.new_vel_a_x  = pipe_s[NST-1].nva[0];
		results.data.new_vel_a_y  = pipe_s[NST-1].nva[1];
		results.data.new_vel_a_z  = pipe_s[NST-1].nva[2];
		results.data.new_vel_b_x  = pipe_s[NST-1].nvb[0];
		results.data.new_vel_b_y  = pipe_s[NST-1].nvb[1];
		results.data.new_vel_b_z  = pipe_s[NST-1].nvb[2];
	end

`ifndef SYNTHESIS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pairs.valid && pairs.ready) |=> vld_s[0])
		else $error("accepted request did not enter first stage");

	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[K_DI] && pipe_s[K_DI].code == CODE_RESOLVED) |-> pipe_s[K_DI].root != '0)
		else $error("zero distance on a resolved contact");

	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[K_N] && pipe_s[K_N].code == CODE_RESOLVED) |->
		($signed(pipe_s[K_N].n[0]) <= 18'sd65536 && $signed(pipe_s[K_N].n[0]) >= -18'sd65536 &&
		 $signed(pipe_s[K_N].n[1]) <= 18'sd65536 && $signed(pipe_s[K_N].n[1]) >= -18'sd65536 &&
		 $signed(pipe_s[K_N].n[2]) <= 18'sd65536 && $signed(pipe_s[K_N].n[2]) >= -18'sd65536))
		else $error("normal component exceeds one");
`endif

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for unit_sphere_collision_response: a fixed-point model
// predicts each result, and the results are compared in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
	import usc_pkg::*;

	localparam longint ONE_Q = 65536;
	localparam longint TWO_Q = 131072;
	localparam longint FOUR_Q32 = 64'sd17179869184;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	usc_stream #(.T(in_t))  pairs_if();
	usc_stream #(.T(out_t)) res_if();

	unit_sphere_collision_response u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs_if),
		.results(res_if)
	);

	out_t expected_q[$];
	int   errors = 0;
	bit   gaps_on = 1;
	bit   hold_req = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint root_floor(longint s);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > s) b = b >>> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic out_t predict_contact(in_t p);
		longint pa[3], pb[3], va[3], vb[3], d[3], nrm[3];
		longint sq, rdist, ovl, dot, jmp, imp;
		bit far;
		out_t r;
		logic signed [31:0] np[3], nva[3], nvb[3];
		code_t code;
		pa[0] = p.pos_a_x; pa[1] = p.pos_a_y; pa[2] = p.pos_a_z;
		pb[0] = p.pos_b_x; pb[1] = p.pos_b_y; pb[2] = p.pos_b_z;
		va[0] = p.vel_a_x; va[1] = p.vel_a_y; va[2] = p.vel_a_z;
		vb[0] = p.vel_b_x; vb[1] = p.vel_b_y; vb[2] = p.vel_b_z;
		far = 0;
		sq = 0;
		for (int c = 0; c < 3; c++) begin
			d[c] = pb[c] - pa[c];
			if (d[c] > TWO_Q || d[c] < -TWO_Q) far = 1;
			np[c] = pa[c];
			nva[c] = va[c];
			nvb[c] = vb[c];
		end
		// squares only formed once every component is within reach
		if (far) begin
			code = CODE_APART;
		end else begin
			for (int c = 0; c < 3; c++) sq += d[c] * d[c];
			if (sq > FOUR_Q32) code = CODE_APART;
			else if (sq == 0) code = CODE_COINCIDENT;
			else code = CODE_RESOLVED;
		end
		if (code == CODE_RESOLVED) begin
			rdist = root_floor(sq);
			ovl = TWO_Q - rdist;
			dot = 0;
			for (int c = 0; c < 3; c++) begin
				nrm[c] = (d[c] * ONE_Q) / rdist;
				np[c] = sat32(pa[c] - (ovl * nrm[c]) / ONE_Q);
				dot += (va[c] - vb[c]) * nrm[c];
			end
			jmp = dot / ONE_Q;
			for (int c = 0; c < 3; c++) begin
				imp = (jmp * nrm[c]) / ONE_Q;
				nva[c] = sat32(va[c] - imp);
				nvb[c] = sat32(vb[c] + imp);
			end
		end
		r.contact_code = code;
		r.new_pos_a_x = np[0]; r.new_pos_a_y = np[1]; r.new_pos_a_z = np[2];
		r.new_vel_a_x = nva[0]; r.new_vel_a_y = nva[1]; r.new_vel_a_z = nva[2];
		r.new_vel_b_x = nvb[0]; r.new_vel_b_y = nvb[1]; r.new_vel_b_z = nvb[2];
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", field, got, want);
		errors++;
	endtask

	// result side: acceptance decided mid-cycle, takes effect at the next edge
	always @(negedge clk) begin
		out_t g, w;
		if (arst_n && res_if.valid && res_if.ready) begin
			g = res_if.data;
			if (expected_q.size() == 0) begin
				$display("mismatch: result with no request outstanding");
				errors++;
			end else begin
				w = expected_q.pop_front();
				if (g.contact_code !== w.contact_code)
					report("contact_code", g.contact_code, w.contact_code);
				if (g.new_pos_a_x !== w.new_pos_a_x)
					report("new_pos_a_x", g.new_pos_a_x, w.new_pos_a_x);
				if (g.new_pos_a_y !== w.new_pos_a_y)
					report("new_pos_a_y", g.new_pos_a_y, w.new_pos_a_y);
				if (g.new_pos_a_z !== w.new_pos_a_z)
					report("new_pos_a_z", g.new_pos_a_z, w.new_pos_a_z);
				if (g.new_vel_a_x !== w.new_vel_a_x)
					report("new_vel_a_x", g.new_vel_a_x, w.new_vel_a_x);
				if (g.new_vel_a_y !== w.new_vel_a_y)
					report("new_vel_a_y", g.new_vel_a_y, w.new_vel_a_y);
				if (g.new_vel_a_z !== w.new_vel_a_z)
					report("new_vel_a_z", g.new_vel_a_z, w.new_vel_a_z);
				if (g.new_vel_b_x !== w.new_vel_b_x)
					report("new_vel_b_x", g.new_vel_b_x, w.new_vel_b_x);
				if (g.new_vel_b_y !== w.new_vel_b_y)
					report("new_vel_b_y", g.new_vel_b_y, w.new_vel_b_y);
				if (g.new_vel_b_z !== w.new_vel_b_z)
					report("new_vel_b_z", g.new_vel_b_z, w.new_vel_b_z);
			end
		end
	end

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		int n;
		res_if.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_if.ready <= 0;
				n = 0;
				while (n < HOLD_CYCLES) begin
					@(posedge clk);
					n++;
				end
				hold_req = 0;
				res_if.ready <= 1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				res_if.ready <= 1;
			end else begin
				res_if.ready <= 1;
			end
		end
	end

	task automatic send_pair(in_t p);
		bit took;
		pairs_if.valid <= 1;
		pairs_if.data <= p;
		took = 0;
		while (!took) begin
			@(negedge clk);
			took = pairs_if.ready;
			@(posedge clk);
		end
		expected_q.push_back(predict_contact(p));
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			pairs_if.valid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rnd32();
		return $urandom;
	endfunction

	function automatic in_t rand_broad();
		in_t p;
		p = {rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
			rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32()};
		return p;
	endfunction

	// near-contact pair: each coordinate of b lies within a little over two radii of a's
	function automatic in_t rand_contact();
		in_t p;
		int span;
		p = rand_broad();
		span = ($urandom_range(0, 3) == 0) ? 140000 : 80000;
		p.pos_b_x = p.pos_a_x + ($signed($urandom_range(0, 2 * span)) - span);
		p.pos_b_y = p.pos_a_y + ($signed($urandom_range(0, 2 * span)) - span);
		p.pos_b_z = p.pos_a_z + ($signed($urandom_range(0, 2 * span)) - span);
		if ($urandom_range(0, 1)) begin
			p.vel_a_x = $signed($urandom_range(0, 800000)) - 400000;
			p.vel_b_z = $signed($urandom_range(0, 800000)) - 400000;
		end
		if ($urandom_range(0, 30) == 0) begin
			p.pos_b_x = p.pos_a_x; p.pos_b_y = p.pos_a_y; p.pos_b_z = p.pos_a_z;
		end
		return p;
	endfunction

	task automatic test_directed();
		in_t p;
		p = '0;
		send_pair(p);                                      // coincident at origin
		p = '1;
		send_pair(p);
		p = {12{32'sh7fffffff}};
		send_pair(p);
		p = {12{32'sh80000000}};
		send_pair(p);
		p = '0; p.pos_b_x = 32'sd131072;                   // exact touch
		p.vel_a_x = 32'sd65536;
		send_pair(p);
		p = '0; p.pos_b_y = -32'sd131073;                  // just beyond reach
		send_pair(p);
		p = '0; p.pos_b_x = 32'sd92682; p.pos_b_y = 32'sd92682; // diagonal, just out
		send_pair(p);
		p = '0; p.pos_b_x = 32'sd92681; p.pos_b_y = 32'sd92681;
		send_pair(p);
		p = '0; p.pos_b_z = 32'sd1;                        // deepest overlap
		send_pair(p);
		// wrapped difference: far apart although the raw bits are close
		p = '0; p.pos_a_x = 32'sh7fffffff; p.pos_b_x = 32'sh80000000;
		send_pair(p);
		// pushout saturates position a
		p = '0; p.pos_a_x = 32'sh7fffffff; p.pos_b_x = 32'sh7ffffff0;
		send_pair(p);
		p = '0; p.pos_a_x = 32'sh80000000; p.pos_b_x = 32'sh80000010;
		send_pair(p);
		// impulse saturates velocities
		p = '0; p.pos_b_x = 32'sd65536;
		p.vel_a_x = 32'sh7fffffff; p.vel_b_x = 32'sh80000000;
		send_pair(p);
		p.vel_a_x = 32'sh80000000; p.vel_b_x = 32'sh7fffffff;
		send_pair(p);
		p = '0; p.pos_b_x = 32'sd50000; p.pos_b_y = -32'sd60000; p.pos_b_z = 32'sd30000;
		p.vel_a_y = 32'sh80000000; p.vel_b_z = 32'sh7fffffff;
		send_pair(p);
		p = '0; p.pos_b_x = -32'sd131072;
		p.vel_a_x = -32'sd65536; p.vel_b_x = 32'sd65536;
		send_pair(p);
	endtask

	task automatic test_contact_random(int count);
		repeat (count) send_pair(rand_contact());
	endtask

	task automatic test_broad_random(int count);
		repeat (count) send_pair(rand_broad());
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		repeat (80) send_pair(rand_contact());
	endtask

	task automatic test_no_idle();
		gaps_on = 0;
		repeat (250) begin
			if ($urandom_range(0, 4) == 0) send_pair(rand_broad());
			else send_pair(rand_contact());
		end
	endtask

	initial begin
		arst_n = 0;
		pairs_if.valid <= 0;
		pairs_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_contact_random(800);
		test_broad_random(250);
		test_backpressure();
		test_no_idle();
		pairs_if.valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
